// ===== rtl/seq_pkg.sv =====
// Package for the sorted event queue: depth, widths, event word type,
// status codes and the per-cell control struct. No dependencies.
package seq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PID_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_DW   = 80;
  localparam int unsigned OUT_DW  = 88;
  localparam int unsigned OUT_PAD = OUT_DW - (PID_W + 2 * TIME_W + OCC_W);

  // Request kinds carried on the input tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // Result status carried on the output tuser
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored event
  typedef struct packed {
    logic [TIME_W-1:0] cpu_time;
    logic [TIME_W-1:0] arrival_time;
    logic [PID_W-1:0]  process_id;
  } event_t;

  // Control handed from the top level to every cell
  typedef struct packed {
    logic ins;       // insert this cycle (queue not full)
    logic pop;       // pop this cycle (queue not empty)
    logic occupied;  // this cell holds a live event
    logic at_tail;   // this cell is the first free slot
  } seq_ctl_t;

endpackage

// ===== rtl/seq_cell.sv =====
// One slot of the sorted queue: holds an event, compares the incoming key
// against its own and shifts toward its neighbors. Uses seq_pkg.
module seq_cell (
  input  logic             clk_i,
  input  seq_pkg::seq_ctl_t ctl_i,
  input  seq_pkg::event_t  new_ev_i,    // event being inserted
  input  seq_pkg::event_t  left_ev_i,   // event of the cell nearer the front
  input  logic             left_take_i, // left cell is shifting right
  input  seq_pkg::event_t  right_ev_i,  // event of the cell nearer the tail
  output seq_pkg::event_t  ev_o,
  output logic             take_o       // this cell shifts right / takes new
);

  seq_pkg::event_t ev_q, ev_d;
  logic            take;

  // New event goes ahead of every stored event with equal or larger time
  always_comb begin
    if (ctl_i.occupied) begin
      take = ctl_i.ins && (new_ev_i.arrival_time <= ev_q.arrival_time);
    end else begin
      take = ctl_i.ins && ctl_i.at_tail;
    end
  end

  // Next slot content
  always_comb begin
    ev_d = ev_q;
    if (take) begin
      ev_d = left_take_i ? left_ev_i : new_ev_i;
    end else if (ctl_i.pop && ctl_i.occupied) begin
      ev_d = right_ev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign ev_o   = ev_q;
  assign take_o = take;

endmodule

// ===== rtl/sorted_event_queue_core.sv =====
// Sorted event queue: top level with the cell chain, occupancy counter and
// output register. Uses seq_pkg and seq_cell.
//
// Usage:
//   Requests enter on the s_axis channel; tuser selects insert or pop,
//   tdata carries the event for an insert. Every request gives exactly one
//   result word on the m_axis channel: status on tuser, the popped event
//   (zero otherwise) and the occupancy after the request on tdata.
//   The queue is a row of DEPTH cells kept sorted by arrival time, smallest
//   at the front. All cells compare the incoming key in parallel and shift
//   together, so a request is finished at the edge that accepts it.
//   Latency: the result word is valid the cycle after acceptance.
//   Throughput: one request per cycle while the output register is free or
//   being read; the occupancy counter and the cell row update at acceptance.
//   Stall: the result sits in one output register; a new request is taken
//   while that word is being taken in the same cycle, and held off while
//   it waits. Ties in arrival time leave newest first. An insert into a
//   full queue or a pop from an empty one leaves the queue unchanged.
//   Reset: the count clears to zero and the output register empties; slot
//   contents are not cleared, no clearing pass is needed.
module sorted_event_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [15:0] process_id, [47:16] arrival_time, [79:48] cpu_time
  input  logic [seq_pkg::IN_DW-1:0]    s_axis_tdata_i,
  // [0] req_type
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [15:0] out_process_id, [47:16] out_arrival_time, [79:48] out_cpu_time,
  // [84:80] occupancy, [87:85] zero
  output logic [seq_pkg::OUT_DW-1:0]   m_axis_tdata_o,
  // [1:0] status
  output logic [seq_pkg::STAT_W-1:0]   m_axis_tuser_o
);

  localparam int unsigned DEPTH = seq_pkg::DEPTH;
  localparam int unsigned CNT_W = seq_pkg::CNT_W;

  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q;
  seq_pkg::status_e   status_q, status_d;
  seq_pkg::event_t    out_ev_q, out_ev_d;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               accept, is_full, is_empty, do_ins, do_pop;
  seq_pkg::event_t    new_ev;
  seq_pkg::event_t    cell_ev   [DEPTH];
  logic               cell_take [DEPTH];

  // Handshake and request decode
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign do_ins   = accept && (s_axis_tuser_i == seq_pkg::REQ_INSERT) && !is_full;
  assign do_pop   = accept && (s_axis_tuser_i == seq_pkg::REQ_POP) && !is_empty;
  assign new_ev   = seq_pkg::event_t'(s_axis_tdata_i);

  // Cell chain: slot 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    seq_pkg::seq_ctl_t ctl;
    seq_pkg::event_t   left_ev, right_ev;
    logic              left_take;

    always_comb begin
      ctl.ins      = do_ins;
      ctl.pop      = do_pop;
      ctl.occupied = (CNT_W'(i) < count_q);
      ctl.at_tail  = (CNT_W'(i) == count_q);
    end

    if (i == 0) begin : g_front
      assign left_ev   = new_ev;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_ev   = cell_ev[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ev = cell_ev[i];
    end else begin : g_body
      assign right_ev = cell_ev[i+1];
    end

    seq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .new_ev_i    (new_ev),
      .left_ev_i   (left_ev),
      .left_take_i (left_take),
      .right_ev_i  (right_ev),
      .ev_o        (cell_ev[i]),
      .take_o      (cell_take[i])
    );
  end

  // Count and result word
  always_comb begin
    count_d  = count_q;
    status_d = seq_pkg::ST_OK;
    out_ev_d = '0;
    if (s_axis_tuser_i == seq_pkg::REQ_INSERT) begin
      if (is_full) begin
        status_d = seq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = seq_pkg::ST_EMPTY;
      end else begin
        count_d  = count_q - CNT_W'(1);
        out_ev_d = cell_ev[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_ev_q  <= out_ev_d;
      out_cnt_q <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {{seq_pkg::OUT_PAD{1'b0}}, seq_pkg::OCC_W'(out_cnt_q), out_ev_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy exceeds depth");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser_i == seq_pkg::REQ_INSERT) && is_full
    |=> (status_q == seq_pkg::ST_FULL) && $stable(count_q))
    else $error("insert into full queue not refused");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (count_q == $past(count_q) - CNT_W'(1)) && (status_q == seq_pkg::ST_OK))
    else $error("pop did not decrement occupancy");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_ev[0].arrival_time <= cell_ev[1].arrival_time))
    else $error("front slots out of order");

endmodule
